[hw/rtl/mlo_pkg.sv]
// shared types, constants and helpers for the median with leave-one-out block
`default_nettype none

package mlo_pkg;

  // set capacity and stored sample width
  localparam int unsigned Depth      = 32;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned SampleW    = 32;
  localparam int unsigned CountW     = $clog2(Depth + 1);
  localparam int unsigned IdxW       = $clog2(Depth);
  // command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCountW    = $clog2(QueueDepth + 1);

  typedef logic signed [SampleW-1:0] sample_t;

  typedef enum logic [1:0] {
    FrLoad,
    FrWindow,
    FrFull,
    FrQuery
  } front_state_e;

  typedef enum logic {
    KindFull = 1'b0,
    KindLoo  = 1'b1
  } kind_e;

  // one command word: the middle of the sorted set plus what to report
  typedef struct packed {
    kind_e   kind;
    logic    last_res;
    logic    overflow;
    logic    single;
    logic    even_n;
    sample_t w0;
    sample_t w1;
    sample_t w2;
    sample_t removed;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // sign extension from the configured data width
  function automatic sample_t sext_in(input sample_t x);
    logic signed [DataWidth-1:0] t;
    t = x[DataWidth-1:0];
    return sample_t'(t);
  endfunction

  // floor of the mean of two values, exact
  function automatic sample_t floor_mean(input sample_t a, input sample_t b);
    logic signed [SampleW:0] s;
    s = {a[SampleW-1], a} + {b[SampleW-1], b};
    return s[SampleW:1];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mlo_if.sv]
// stream interfaces for sample input and result output
`default_nettype none

interface mlo_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       sample;
  logic                     marked;
  logic                     last;
  modport source (output valid, output sample, output marked, output last, input ready);
  modport sink   (input valid, input sample, input marked, input last, output ready);
endinterface

interface mlo_out_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [31:0]       median_value;
  logic signed [31:0]       removed_value;
  logic                     defined;
  logic                     same_as_median;
  logic                     any_same;
  logic                     overflow;
  logic                     last_res;
  modport source (output valid, output kind, output median_value, output removed_value,
                  output defined, output same_as_median, output any_same,
                  output overflow, output last_res, input ready);
  modport sink   (input valid, input kind, input median_value, input removed_value,
                  input defined, input same_as_median, input any_same,
                  input overflow, input last_res, output ready);
endinterface

`default_nettype wire

[hw/rtl/mlo_ram.sv]
// generic single write, single registered read ram
`default_nettype none

module mlo_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/mlo_queue.sv]
// short command queue between front and back
`default_nettype none

module mlo_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire mlo_pkg::cmd_t          cmd_i,
  input  wire logic                   pop_i,
  output mlo_pkg::cmd_t               cmd_o,
  output mlo_pkg::queue_status_t      status_o
);
  import mlo_pkg::*;

  cmd_t               slot_q [QueueDepth];
  logic [QPtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCountW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign status_o.full  = (cnt_q == QCountW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign cmd_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mlo_front.sv]
// front: insertion-sort cell chain, query store and command issue
`default_nettype none

module mlo_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  mlo_in_if.sink                      in_i,
  input  wire mlo_pkg::queue_status_t qstat_i,
  output logic                        push_o,
  output mlo_pkg::cmd_t               cmd_o
);
  import mlo_pkg::*;

  front_state_e      state_q, state_d;
  sample_t           cell_q [Depth];
  sample_t           cell_d [Depth];
  logic [Depth-1:0]  gt;
  logic [CountW-1:0] n_q, n_d, qc_q, qc_d, qidx_q, qidx_d;
  logic              ovf_q, ovf_d;
  sample_t           w0_q, w1_q, w2_q, v;
  logic [IdxW-1:0]   hp, ib, i2, raddr;
  logic              accept, store, ram_we;
  logic [SampleW-1:0] rdata;

  assign accept = in_i.valid && in_i.ready;
  assign store  = accept && (n_q < CountW'(Depth));
  assign v      = sext_in(in_i.sample);
  assign ram_we = store && in_i.marked;

  // per-cell insert: keep, take the new value, or shift up from below
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      gt[i] = (CountW'(i) < n_q) && (cell_q[i] > v);
    end
    for (int i = 0; i < Depth; i++) begin
      cell_d[i] = cell_q[i];
      if (store && (CountW'(i) <= n_q) && !((CountW'(i) < n_q) && !gt[i])) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end else begin
          cell_d[i] = v;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  mlo_ram #(.Width(SampleW), .Depth(Depth)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (qc_q[IdxW-1:0]),
    .wdata_i (v),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // middle window around the median position
  assign hp = IdxW'((n_q - 1'b1) >> 1);
  assign ib = (hp == '0) ? '0 : hp - 1'b1;
  assign i2 = (hp == IdxW'(Depth - 1)) ? hp : hp + 1'b1;

  always_ff @(posedge clk_i) begin
    if (state_q == FrWindow) begin
      w0_q <= cell_q[ib];
      w1_q <= cell_q[hp];
      w2_q <= cell_q[i2];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FrLoad:   if (accept && in_i.last) state_d = FrWindow;
      FrWindow: state_d = FrFull;
      FrFull: begin
        if (!qstat_i.full) state_d = (qc_q == '0) ? FrLoad : FrQuery;
      end
      FrQuery: begin
        if (!qstat_i.full && (qidx_q + 1'b1 == qc_q)) state_d = FrLoad;
      end
      default: state_d = FrLoad;
    endcase
  end

  // outputs and run counters
  always_comb begin
    in_i.ready = 1'b0;
    push_o     = 1'b0;
    n_d        = n_q;
    qc_d       = qc_q;
    ovf_d      = ovf_q;
    qidx_d     = qidx_q;
    cmd_o.kind     = KindFull;
    cmd_o.last_res = (qc_q == '0);
    cmd_o.overflow = ovf_q;
    cmd_o.single   = (n_q == CountW'(1));
    cmd_o.even_n   = !n_q[0];
    cmd_o.w0       = w0_q;
    cmd_o.w1       = w1_q;
    cmd_o.w2       = w2_q;
    cmd_o.removed  = '0;
    unique case (state_q)
      FrLoad: begin
        in_i.ready = 1'b1;
        if (store) begin
          n_d = n_q + 1'b1;
          if (in_i.marked) qc_d = qc_q + 1'b1;
        end else if (accept) begin
          ovf_d = 1'b1;
        end
      end
      FrWindow: qidx_d = '0;
      FrFull: begin
        push_o = !qstat_i.full;
      end
      FrQuery: begin
        push_o         = !qstat_i.full;
        cmd_o.kind     = KindLoo;
        cmd_o.last_res = (qidx_q + 1'b1 == qc_q);
        cmd_o.removed  = rdata;
        if (push_o) qidx_d = qidx_q + 1'b1;
      end
      default: ;
    endcase
    if (push_o && cmd_o.last_res) begin
      n_d   = '0;
      qc_d  = '0;
      ovf_d = 1'b0;
    end
  end

  // read ahead so the query word is ready when its command goes out
  assign raddr = (state_q == FrQuery && push_o) ? IdxW'(qidx_q + 1'b1) : IdxW'(qidx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrLoad;
      n_q     <= '0;
      qc_q    <= '0;
      qidx_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      qc_q    <= qc_d;
      qidx_q  <= qidx_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mlo_back.sv]
// back: median arithmetic and output register
`default_nettype none

module mlo_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mlo_pkg::cmd_t          cmd_i,
  input  wire mlo_pkg::queue_status_t qstat_i,
  output logic                        pop_o,
  mlo_out_if.source                   out_o
);
  import mlo_pkg::*;

  logic    valid_q, eq_q, eq_d;
  sample_t full_med, e0, e1, loo_med, med;
  logic    same, defined;

  assign full_med = cmd_i.even_n ? floor_mean(cmd_i.w1, cmd_i.w2) : cmd_i.w1;
  assign e0       = (cmd_i.w0 < cmd_i.removed) ? cmd_i.w0 : cmd_i.w1;
  assign e1       = (cmd_i.w1 < cmd_i.removed) ? cmd_i.w1 : cmd_i.w2;
  assign loo_med  = cmd_i.even_n ? e1 : floor_mean(e0, e1);

  always_comb begin
    defined = 1'b1;
    same    = 1'b0;
    med     = full_med;
    if (cmd_i.kind == KindLoo) begin
      defined = !cmd_i.single;
      med     = defined ? loo_med : '0;
      same    = defined && (loo_med == full_med);
    end
  end

  assign pop_o = !qstat_i.empty && (!valid_q || out_o.ready);
  assign eq_d  = (eq_q || same) && !cmd_i.last_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        eq_q    <= eq_d;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_o.kind           <= cmd_i.kind;
      out_o.median_value   <= med;
      out_o.removed_value  <= cmd_i.removed;
      out_o.defined        <= defined;
      out_o.same_as_median <= same;
      out_o.any_same       <= eq_q || same;
      out_o.overflow       <= cmd_i.overflow;
      out_o.last_res       <= cmd_i.last_res;
    end
  end

  assign out_o.valid = valid_q;

endmodule

`default_nettype wire

[hw/rtl/median_with_leave_one_out_top.sv]
// top level of the median with leave-one-out block
`default_nettype none

// takes a set of signed q16.16 samples, one word per cycle while loading, into
// an insertion-sort cell chain of 32 cells; a marked sample is also kept in a
// query ram. the word flagged last closes the set: the front latches the
// middle of the chain, then issues one command for the full median and one
// per marked sample, one per cycle while the queue has room, and the back
// turns each into a result word. the next set is taken only after the last
// command of this one is issued; samples beyond 32 are dropped and flagged
// as overflow. even counts give the floor of the mean of the two middle
// values. the queue of two command words and the output register let the
// back stall on its own
module median_with_leave_one_out_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mlo_in_if.sink    in_i,
  mlo_out_if.source out_o
);
  import mlo_pkg::*;

  // front to queue
  logic          push;
  cmd_t          cmd_in;
  // queue to back
  cmd_t          cmd_head;
  logic          pop;
  queue_status_t qstat;

  // sorting chain, query store and command issue
  mlo_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (cmd_in)
  );

  // decoupling queue
  mlo_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .cmd_o    (cmd_head),
    .status_o (qstat)
  );

  // median arithmetic and output word
  mlo_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // queue cannot be full and empty at once
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty");

  // a full-set result never carries leave-one-out fields
  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KindFull) |->
      (out_o.removed_value == '0 && !out_o.same_as_median && out_o.defined))
    else $error("full median word with leave-one-out fields");

  // an undefined result is zero and not equal
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.defined) |->
      (out_o.median_value == '0 && !out_o.same_as_median))
    else $error("undefined result not zero");

  // the sticky flag covers the current result
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.same_as_median) |-> out_o.any_same)
    else $error("sticky flag missed an equal result");
`endif

endmodule

`default_nettype wire

[test/mlo_sb.sv]
// scoreboard class for the median with leave-one-out block
package mlo_sb_pkg;
  import mlo_pkg::*;

  typedef struct packed {
    logic    kind;
    sample_t median_value;
    sample_t removed_value;
    logic    defined;
    logic    same_as_median;
    logic    any_same;
    logic    overflow;
    logic    last_res;
  } result_t;

  class median_scoreboard;
    sample_t sorted_set[$];
    sample_t marked_set[$];
    logic    overflow_seen;
    result_t pending[$];
    int      errors;
    int      words_checked;
    int      sets_closed;

    function new();
      overflow_seen = 1'b0;
      errors = 0;
      words_checked = 0;
      sets_closed = 0;
    endfunction

    // element k of the sorted set with index skip removed
    function sample_t pick(int k, int skip);
      int i;
      i = (k < skip) ? k : k + 1;
      return sorted_set[i];
    endfunction

    function sample_t mid_of(int m, int skip);
      sample_t lo, hi;
      logic signed [32:0] s;
      if (m == 0) return '0;
      if (m % 2 == 1) return pick(m / 2, skip);
      lo = pick(m / 2 - 1, skip);
      hi = pick(m / 2, skip);
      s = {lo[31], lo} + {hi[31], hi};
      return s[32:1];
    endfunction

    // note an accepted sample word, queue results when it closes a set
    function void note_sample(sample_t v, logic mk, logic lst);
      int pos, n, r;
      sample_t full, med;
      logic eq_seen, def, same;
      result_t res;
      if (sorted_set.size() < Depth) begin
        pos = sorted_set.size();
        while (pos > 0 && sorted_set[pos-1] > v) pos--;
        sorted_set.insert(pos, v);
        if (mk) marked_set.insert(marked_set.size(), v);
      end else begin
        overflow_seen = 1'b1;
      end
      if (!lst) return;
      sets_closed++;
      n = sorted_set.size();
      eq_seen = 1'b0;
      full = mid_of(n, Depth + 1);
      res = '{KindFull, full, '0, 1'b1, 1'b0, 1'b0, overflow_seen,
              marked_set.size() == 0};
      pending.insert(pending.size(), res);
      foreach (marked_set[q]) begin
        r = 0;
        for (int i = 0; i < n; i++)
          if (sorted_set[i] == marked_set[q]) begin
            r = i;
            break;
          end
        def = n > 1;
        med = '0;
        same = 1'b0;
        if (def) begin
          med = mid_of(n - 1, r);
          same = med == full;
          if (same) eq_seen = 1'b1;
        end
        res = '{KindLoo, med, marked_set[q], def, same, eq_seen, overflow_seen,
                q == marked_set.size() - 1};
        pending.insert(pending.size(), res);
      end
      sorted_set.delete();
      marked_set.delete();
      overflow_seen = 1'b0;
    endfunction

    // compare one result word with the oldest expectation, 0 fields on success
    function int check_result(result_t got, output result_t exp);
      int bad;
      bad = 0;
      words_checked++;
      if (pending.size() == 0) begin
        exp = '0;
        return -1;
      end
      exp = pending.pop_front();
      if (got.kind != exp.kind) bad++;
      if (got.median_value != exp.median_value) bad++;
      if (got.removed_value != exp.removed_value) bad++;
      if (got.defined != exp.defined) bad++;
      if (got.same_as_median != exp.same_as_median) bad++;
      if (got.any_same != exp.any_same) bad++;
      if (got.overflow != exp.overflow) bad++;
      if (got.last_res != exp.last_res) bad++;
      return bad;
    endfunction
  endclass
endpackage

[test/tb.sv]
// testbench top for the median with leave-one-out block
module tb;
  import mlo_pkg::*;
  import mlo_sb_pkg::*;

  logic clk_i;
  logic rst_ni;

  mlo_in_if  in_if ();
  mlo_out_if out_if ();

  median_with_leave_one_out_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  median_scoreboard board;

  // idle percentages for sender and receiver, changed per phase
  int send_idle_pct;
  int recv_idle_pct;
  // long receiver hold-off, counted in cycles by the ready process
  int  hold_cycles;
  int  word_count;
  int  result_count;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // one line per mismatch, counted in the scoreboard
  task automatic report(string what, result_t got, result_t exp);
    board.errors++;
    $display({"mismatch %s: got k%0b m%0d r%0d d%0b s%0b a%0b o%0b l%0b,",
              " exp k%0b m%0d r%0d d%0b s%0b a%0b o%0b l%0b"},
             what, got.kind, got.median_value, got.removed_value, got.defined,
             got.same_as_median, got.any_same, got.overflow, got.last_res,
             exp.kind, exp.median_value, exp.removed_value, exp.defined,
             exp.same_as_median, exp.any_same, exp.overflow, exp.last_res);
  endtask

  // send one sample word; gaps taken before it at the falling edge
  task automatic send_word(sample_t v, logic mk, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= v;
    in_if.marked <= mk;
    in_if.last   <= lst;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_sample(v, mk, lst);
    word_count++;
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
  endtask

  // random value, biased toward extremes and repeats so ties are common
  function automatic sample_t rand_sample();
    case ($urandom_range(5))
      0: return 32'sh8000_0000 + $urandom_range(3);
      1: return 32'sh7fff_ffff - $urandom_range(3);
      2: return sample_t'($urandom_range(8)) - 4;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // one random set of the given size; last word closes it
  task automatic send_set(int n, int mark_pct);
    for (int i = 0; i < n; i++)
      send_word(rand_sample(), $urandom_range(99) < mark_pct, i == n - 1);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    go_idle();
    while (board.pending.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (40) @(negedge clk_i);
  endtask

  // receiver: ready drawn at the falling edge, results checked at the rising
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    result_t got, exp;
    int bad;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.kind, out_if.median_value, out_if.removed_value, out_if.defined,
              out_if.same_as_median, out_if.any_same, out_if.overflow, out_if.last_res};
      result_count++;
      bad = board.check_result(got, exp);
      if (bad < 0) report("unexpected word", got, exp);
      else if (bad > 0) report("field", got, exp);
    end
  end

  initial begin
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    word_count = 0;
    result_count = 0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.marked = 1'b0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: single sample, marked, gives an undefined leave-one-out
    send_word(32'sh7fff_ffff, 1'b1, 1'b1);
    // two extremes, both marked: even floor mean across the sign
    send_word(32'sh8000_0000, 1'b1, 1'b0);
    send_word(32'sh7fff_ffff, 1'b1, 1'b1);
    // even count with duplicates, unmarked and marked mix
    send_word(32'sd5, 1'b0, 1'b0);
    send_word(-32'sd3, 1'b1, 1'b0);
    send_word(32'sd5, 1'b1, 1'b0);
    send_word(-32'sd1, 1'b0, 1'b1);
    // no marks at all
    send_word(32'sd0, 1'b0, 1'b1);
    // overflow: 34 words, the dropped last still closes the set
    for (int i = 0; i < 34; i++)
      send_word(sample_t'($urandom()), i < 3, i == 33);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 56 : 10) : 0;
      recv_idle_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 56 : 10) : 0;
      if (ph == 2) hold_cycles = 300;  // long hold-off while samples keep coming
      while (word_count < 60 + (ph + 1) * 80) begin
        case ($urandom_range(9))
          0: send_set(1, 50);
          1: send_set(32 + $urandom_range(3), 20);
          default: send_set(1 + $urandom_range(12), $urandom_range(100));
        endcase
      end
      drain();
    end

    $display("covered %0d sample words in %0d sets, %0d result words checked",
             word_count, board.sets_closed, result_count);
    $display("phases: directed corners, overflow, free run, idle sender, stalls, hold-off");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[files.f]
hw/rtl/mlo_pkg.sv
hw/rtl/mlo_if.sv
hw/rtl/mlo_ram.sv
hw/rtl/mlo_queue.sv
hw/rtl/mlo_front.sv
hw/rtl/mlo_back.sv
hw/rtl/median_with_leave_one_out_top.sv
test/mlo_sb.sv
test/tb.sv
